FILE: rtl/capacity_bounded_stack_of_stacks_defines.svh
// Assertion macros shared by the capacity-bounded stack of stacks RTL.
`ifndef CAPACITY_BOUNDED_STACK_OF_STACKS_DEFINES_SVH
`define CAPACITY_BOUNDED_STACK_OF_STACKS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbss same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbss next-cycle check failed");

`endif

FILE: rtl/cbss_pkg.sv
// Package with shared constants and types of the capacity-bounded stack of stacks.
package cbss_pkg;

    localparam int DEF_STORE_DEPTH = 256;
    localparam int DEF_VALUE_BITS  = 16;

    localparam int          FIELD_BITS      = 16;
    localparam int          COUNT_OUT_BITS  = 9;
    localparam int          OUT_TDATA_BITS  = 48;
    localparam logic [15:0] SUM_LIMIT_RESET = 16'd1000;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

endpackage

FILE: rtl/capacity_bounded_stack_of_stacks.sv
// Top level of the capacity-bounded stack of stacks.
//
//  Channel   Direction  Signals                         Contents
//  s         in         i_s_tvalid/o_s_tready           tdata push_value, tuser command
//  m         out        o_m_tvalid/i_m_tready           tdata result sums, tuser push_dropped
//  cfg       in         i_cfg_wr_en/i_cfg_wr_data       sum_limit
//
// Each request first reads the value and sub-stack sum RAMs as it is accepted in S_IDLE,
// then in S_EXEC updates them and loads the result register.
// A new request is taken while the previous result still waits on the m side.
// If the result register is still full, the update cycle waits until it drains.
// Reset is synchronous; it clears the counts and the cached top sum and sets sum_limit to 1000.
`include "capacity_bounded_stack_of_stacks_defines.svh"

module capacity_bounded_stack_of_stacks #(
    parameter int STORE_DEPTH = cbss_pkg::DEF_STORE_DEPTH,
    parameter int VALUE_BITS  = cbss_pkg::DEF_VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // push_value[15:0]
    input  logic        i_s_tuser,   // command[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // popped_value[15:0], sub_stack_count[24:16],
                                     // top_sum[40:25], zero fill[47:41]
    output logic        o_m_tuser,   // push_dropped[0]
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int SUMW = (VALUE_BITS > cbss_pkg::FIELD_BITS) ? VALUE_BITS
                                                              : cbss_pkg::FIELD_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state               r_state;
    logic [15:0]          r_limit;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_open, n_open;
    logic [SUMW-1:0]      r_top_sum, n_top_sum;
    cbss_pkg::t_cmd       r_cmd;
    logic [VALUE_BITS-1:0] r_val;
    logic                 r_ovalid;
    logic [15:0]          r_o_pop;
    logic [cbss_pkg::COUNT_OUT_BITS-1:0] r_o_count;
    logic [15:0]          r_o_top;
    logic                 r_o_drop;

    logic                 s_accept;
    logic                 commit;
    logic [15:0]          n_pop;
    logic                 n_drop;
    logic                 val_we, sum_we;
    logic [AW-1:0]        val_waddr, sum_waddr;
    logic [SUMW-1:0]      sum_wdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [SUMW-1:0]      sum_rdata;
    logic [SUMW:0]        join_sum;
    logic [SUMW-1:0]      pop_ext, after_pop;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign commit     = (r_state == S_EXEC) && (!r_ovalid || i_m_tready);

    cbss_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_val),
        .i_re    (s_accept),
        .i_raddr (AW'(r_cnt - CW'(1))),
        .o_rdata (val_rdata)
    );

    cbss_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (SUMW)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (s_accept),
        .i_raddr (AW'(r_open - CW'(2))),
        .o_rdata (sum_rdata)
    );

    assign join_sum  = {1'b0, r_top_sum} + {{(SUMW + 1 - VALUE_BITS){1'b0}}, r_val};
    assign pop_ext   = SUMW'(val_rdata);
    assign after_pop = (r_top_sum >= pop_ext) ? (r_top_sum - pop_ext) : '0;

    always_comb begin
        n_cnt     = r_cnt;
        n_open    = r_open;
        n_top_sum = r_top_sum;
        n_pop     = '0;
        n_drop    = 1'b0;
        val_we    = 1'b0;
        val_waddr = AW'(r_cnt);
        sum_we    = 1'b0;
        sum_waddr = AW'(r_open - CW'(1));
        sum_wdata = after_pop;
        if (commit) begin
            unique case (r_cmd)
                cbss_pkg::CMD_PUSH: begin
                    if (r_val != '0) begin
                        if (r_cnt >= DEPTH_C) begin
                            n_drop = 1'b1;
                        end else if ((r_open == '0) ||
                                     (join_sum > (SUMW + 1)'(r_limit))) begin
                            if (r_open >= DEPTH_C) begin
                                n_drop = 1'b1;
                            end else begin
                                val_we    = 1'b1;
                                n_cnt     = r_cnt + CW'(1);
                                sum_we    = 1'b1;
                                sum_waddr = AW'(r_open);
                                sum_wdata = SUMW'(r_val);
                                n_top_sum = SUMW'(r_val);
                                n_open    = r_open + CW'(1);
                            end
                        end else begin
                            val_we    = 1'b1;
                            n_cnt     = r_cnt + CW'(1);
                            sum_we    = 1'b1;
                            sum_wdata = SUMW'(join_sum);
                            n_top_sum = SUMW'(join_sum);
                        end
                    end
                end
                cbss_pkg::CMD_POP: begin
                    if ((r_open != '0) && (r_cnt != '0)) begin
                        n_cnt = r_cnt - CW'(1);
                        n_pop = 16'(val_rdata);
                        if (after_pop == '0) begin
                            n_open    = r_open - CW'(1);
                            n_top_sum = (r_open > CW'(1)) ? sum_rdata : '0;
                        end else begin
                            sum_we    = 1'b1;
                            n_top_sum = after_pop;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= cbss_pkg::SUM_LIMIT_RESET;
            r_cnt     <= '0;
            r_open    <= '0;
            r_top_sum <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_ovalid <= commit || (r_ovalid && !(o_m_tvalid && i_m_tready));
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state   <= S_IDLE;
                        r_cnt     <= n_cnt;
                        r_open    <= n_open;
                        r_top_sum <= n_top_sum;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= cbss_pkg::t_cmd'(i_s_tuser);
            r_val <= VALUE_BITS'(i_s_tdata);
        end
        if (commit) begin
            r_o_pop   <= n_pop;
            r_o_count <= cbss_pkg::COUNT_OUT_BITS'(n_open);
            r_o_top   <= 16'(n_top_sum);
            r_o_drop  <= n_drop;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(cbss_pkg::OUT_TDATA_BITS - 41){1'b0}}, r_o_top, r_o_count, r_o_pop};
    assign o_m_tuser  = r_o_drop;

    `CBSS_ASSERT_NOW(a_open_le_cnt, i_clk, i_rst_n, 1'b1, r_open <= r_cnt)
    `CBSS_ASSERT_NOW(a_empty_top_zero, i_clk, i_rst_n, r_open == '0, r_top_sum == '0)
    `CBSS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, s_accept, r_state == S_EXEC)
    `CBSS_ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, commit, o_m_tvalid)

endmodule

FILE: rtl/cbss_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module cbss_ram #(
    parameter int DEPTH = cbss_pkg::DEF_STORE_DEPTH,
    parameter int WIDTH = cbss_pkg::DEF_VALUE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/tb_capacity_bounded_stack_of_stacks.sv
// Self-checking testbench for the capacity-bounded stack of stacks.
`timescale 1ns / 1ps

module tb_capacity_bounded_stack_of_stacks;

    localparam int DEPTH = cbss_pkg::DEF_STORE_DEPTH;

    typedef struct packed {
        logic [15:0] popped;
        logic [8:0]  sub_count;
        logic [15:0] top_sum;
        logic        dropped;
    } t_stack_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    logic [15:0]   limit_q;
    logic [15:0]   held_values [DEPTH];
    logic [15:0]   sub_sums [DEPTH];
    int unsigned   held_n;
    int unsigned   open_n;
    t_stack_result pending_results [$];
    int            error_count;
    bit            sender_idle;
    bit            receiver_idle;

    capacity_bounded_stack_of_stacks u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_stack_result predict_request(input cbss_pkg::t_cmd cmd,
                                                      input logic [15:0] value);
        t_stack_result r;
        int unsigned   t;
        r = '0;
        if (cmd == cbss_pkg::CMD_PUSH) begin
            if (value != 16'd0) begin
                if (held_n >= DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    if (open_n == 0 ||
                        ({1'b0, sub_sums[open_n - 1]} + {1'b0, value}) > {1'b0, limit_q}) begin
                        if (open_n >= DEPTH) begin
                            r.dropped = 1'b1;
                        end else begin
                            sub_sums[open_n] = 16'd0;
                            open_n++;
                        end
                    end
                    if (!r.dropped) begin
                        held_values[held_n] = value;
                        held_n++;
                        sub_sums[open_n - 1] = sub_sums[open_n - 1] + value;
                    end
                end
            end
        end else if (open_n != 0 && held_n != 0) begin
            held_n--;
            r.popped = held_values[held_n];
            t = open_n - 1;
            sub_sums[t] = (sub_sums[t] >= r.popped) ? sub_sums[t] - r.popped : 16'd0;
            if (sub_sums[t] == 16'd0) begin
                open_n--;
            end
        end
        r.sub_count = open_n[8:0];
        r.top_sum   = (open_n == 0) ? 16'd0 : sub_sums[open_n - 1];
        return r;
    endfunction

    function automatic logic [15:0] random_value();
        int unsigned hi;
        hi = (limit_q > 16'd4) ? limit_q / 3 : ((limit_q == 16'd0) ? 1 : limit_q);
        case ($urandom_range(0, 9))
            0: begin
                return 16'd0;
            end
            1, 2: begin
                return 16'($urandom_range(0, 65535));
            end
            3: begin
                return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
            end
            default: begin
                return 16'($urandom_range(1, hi));
            end
        endcase
    endfunction

    task automatic send_request(input cbss_pkg::t_cmd cmd, input logic [15:0] value);
        int gap;
        gap = sender_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_request(cmd, value));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_sum_limit(input logic [15:0] limit);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_q = limit;
    endtask

    task automatic send_random_request(input int push_percent);
        if ($urandom_range(1, 100) <= push_percent) begin
            send_request(cbss_pkg::CMD_PUSH, random_value());
        end else begin
            send_request(cbss_pkg::CMD_POP, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_directed_sequence();
        send_request(cbss_pkg::CMD_POP, 16'h5A5A);
        send_request(cbss_pkg::CMD_PUSH, 16'd0);
        send_request(cbss_pkg::CMD_PUSH, 16'd400);
        send_request(cbss_pkg::CMD_PUSH, 16'd600);
        send_request(cbss_pkg::CMD_PUSH, 16'd1);
        send_request(cbss_pkg::CMD_PUSH, 16'hFFFF);
        send_request(cbss_pkg::CMD_PUSH, 16'd999);
        wait_for_results();
        send_request(cbss_pkg::CMD_POP, 16'hFFFF);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_PUSH, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
    endtask

    task automatic test_limit_extremes();
        write_sum_limit(16'hFFFF);
        send_request(cbss_pkg::CMD_PUSH, 16'hFFFF);
        send_request(cbss_pkg::CMD_PUSH, 16'd1);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        write_sum_limit(16'd0);
        send_request(cbss_pkg::CMD_PUSH, 16'd1);
        send_request(cbss_pkg::CMD_PUSH, 16'd1);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        write_sum_limit(16'd1);
        send_request(cbss_pkg::CMD_PUSH, 16'd1);
        send_request(cbss_pkg::CMD_PUSH, 16'd2);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'd0);
    endtask

    task automatic test_fill_until_full();
        write_sum_limit(16'($urandom_range(100, 4000)));
        sender_idle   = 1'b1;
        receiver_idle = 1'b0;
        while (held_n < DEPTH) send_random_request(95);
        send_request(cbss_pkg::CMD_PUSH, 16'hFFFF);
        send_request(cbss_pkg::CMD_PUSH, 16'd1);
        send_request(cbss_pkg::CMD_PUSH, 16'($urandom_range(1, 65535)));
    endtask

    task automatic test_drain_until_empty();
        write_sum_limit(16'($urandom_range(1, 65535)));
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        while (held_n > 0) send_random_request(5);
        send_request(cbss_pkg::CMD_POP, 16'd0);
        send_request(cbss_pkg::CMD_POP, 16'hFFFF);
    endtask

    task automatic test_random_mix();
        logic [15:0] limits [4];
        limits[0] = 16'd1;
        limits[1] = 16'hFFFF;
        limits[2] = 16'($urandom_range(2, 50));
        limits[3] = 16'($urandom_range(1, 65535));
        for (int p = 0; p < 4; p++) begin
            write_sum_limit(limits[p]);
            sender_idle   = (p != 2);
            receiver_idle = (p != 1);
            repeat (30) send_random_request(55);
        end
    endtask

    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        t_stack_result want;
        t_stack_result seen;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                seen.popped    = o_m_tdata[15:0];
                seen.sub_count = o_m_tdata[24:16];
                seen.top_sum   = o_m_tdata[40:25];
                seen.dropped   = o_m_tuser;
                if (pending_results.size() == 0) begin
                    $error("result with no request waiting: tdata %h tuser %b",
                           o_m_tdata, o_m_tuser);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (seen.popped !== want.popped) begin
                        $error("popped_value expected %0d got %0d", want.popped, seen.popped);
                        error_count++;
                    end
                    if (seen.sub_count !== want.sub_count) begin
                        $error("sub_stack_count expected %0d got %0d",
                               want.sub_count, seen.sub_count);
                        error_count++;
                    end
                    if (seen.top_sum !== want.top_sum) begin
                        $error("top_sum expected %0d got %0d", want.top_sum, seen.top_sum);
                        error_count++;
                    end
                    if (seen.dropped !== want.dropped) begin
                        $error("push_dropped expected %0d got %0d", want.dropped, seen.dropped);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 16'd0;
        i_s_tuser     = cbss_pkg::CMD_PUSH;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 16'd0;
        limit_q       = cbss_pkg::SUM_LIMIT_RESET;
        held_n        = 0;
        open_n        = 0;
        error_count   = 0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_sequence();
        test_limit_extremes();
        test_fill_until_full();
        test_drain_until_empty();
        test_random_mix();

        wait_for_results();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
